// File: design/b2da_pkg.sv
package b2da_pkg;

   localparam int unsigned DIGIT_BITS = 4;
   localparam int unsigned CHAR_BITS  = 6;
   localparam logic [CHAR_BITS-1:0]  CHAR_ZERO  = 6'd48;
   localparam logic [DIGIT_BITS-1:0] DIGIT_FIVE = 4'd5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT
   } state_type;

   // control broadcast to every digit cell
   typedef struct packed {
      logic clear;    // zero the digit
      logic dabble;   // adjust and shift one binary bit in
      logic advance;  // take the digit of the lower neighbor
   } cell_ctrl_type;

endpackage

// File: design/b2da_if.sv
interface b2da_req_if #(parameter int unsigned VALUE_BITS = 32);
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface b2da_rsp_if;
   logic       valid;
   logic       ready;
   logic [5:0] digit_char;
   logic       last_digit;

   modport source (output valid, output digit_char, output last_digit, input ready);
   modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

// File: design/b2da_cell.sv
module b2da_cell
   import b2da_pkg::*;
(
   input  logic                  clock,
   input  cell_ctrl_type         ctrl,
   input  logic                  nbr_bit,
   input  logic [DIGIT_BITS-1:0] nbr_digit,
   output logic                  carry_out,
   output logic [DIGIT_BITS-1:0] digit
);

   logic [DIGIT_BITS-1:0] digit_ff;
   logic [DIGIT_BITS-1:0] digit_in;
   logic [DIGIT_BITS-1:0] adj;
   logic                  big;

   // subtract-5-then-shift: digits of five or more carry into the next cell
   always_comb begin
      big = (digit_ff >= DIGIT_FIVE);
      adj = big ? (digit_ff - DIGIT_FIVE) : digit_ff;
      if (ctrl.clear) begin
         digit_in = '0;
      end else if (ctrl.dabble) begin
         digit_in = {adj[DIGIT_BITS-2:0], nbr_bit};
      end else if (ctrl.advance) begin
         digit_in = nbr_digit;
      end else begin
         digit_in = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign carry_out = big;
   assign digit     = digit_ff;

endmodule

// File: design/binary_to_decimal_ascii.sv
// Channel  Direction  Payload
// req_bus  in         value [VALUE_BITS-1:0]
// rsp_bus  out        digit_char [5:0], last_digit
//
// One item at a time: the idle state takes the value, then the convert state
// shifts each value bit in with an adjust through a row of MAX_DIGITS BCD cells,
// then the emit state walks the MAX_DIGITS cells (leading zeros are skipped
// without output, and output stalls hold the emit phase).
// Synchronous reset returns the controller to idle; the cells need none.
// req_bus.ready is high only while idle; a stalled digit holds in the top cell.
module binary_to_decimal_ascii
   import b2da_pkg::*;
#(
   parameter int unsigned VALUE_BITS = 32,
   parameter int unsigned MAX_DIGITS = 10
) (
   input  logic        clock,
   input  logic        reset,
   b2da_req_if.sink    req_bus,
   b2da_rsp_if.source  rsp_bus
);

   localparam int unsigned CNT_W  = $clog2(VALUE_BITS + 1);
   localparam int unsigned DCNT_W = $clog2(MAX_DIGITS + 1);

   state_type             state_ff, state_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic [CNT_W-1:0]      bit_cnt_ff, bit_cnt_in;
   logic [DCNT_W-1:0]     digit_cnt_ff, digit_cnt_in;
   logic                  started_ff, started_in;
   logic                  overflow_ff, overflow_in;

   cell_ctrl_type         ctrl;
   logic                  show;
   logic                  req_take;
   logic                  rsp_take;
   logic                  last_now;

   logic [MAX_DIGITS-1:0] carry;
   logic [DIGIT_BITS-1:0] digit [MAX_DIGITS];
   logic [DIGIT_BITS-1:0] top_digit;

   // cell 0 takes the value MSB; each cell feeds its carry and digit upward
   for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
      if (i == 0) begin : g_first
         b2da_cell u_cell (
            .clock     (clock),
            .ctrl      (ctrl),
            .nbr_bit   (value_ff[VALUE_BITS-1]),
            .nbr_digit ('0),
            .carry_out (carry[i]),
            .digit     (digit[i])
         );
      end else begin : g_rest
         b2da_cell u_cell (
            .clock     (clock),
            .ctrl      (ctrl),
            .nbr_bit   (carry[i-1]),
            .nbr_digit (digit[i-1]),
            .carry_out (carry[i]),
            .digit     (digit[i])
         );
      end
   end

   assign top_digit = digit[MAX_DIGITS-1];
   assign last_now  = (digit_cnt_ff == DCNT_W'(1));
   // after truncation every kept digit is shown, zeros included
   assign show      = (state_ff == ST_EMIT) &&
                      (started_ff || overflow_ff || (top_digit != '0) || last_now);
   assign req_take  = req_bus.valid && req_bus.ready;
   assign rsp_take  = rsp_bus.valid && rsp_bus.ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            if (bit_cnt_ff == CNT_W'(1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_take && last_now) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl          = '0;
      req_bus.ready = 1'b0;
      rsp_bus.valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            ctrl.clear    = req_take;
         end
         ST_CONVERT: begin
            ctrl.dabble = 1'b1;
         end
         ST_EMIT: begin
            rsp_bus.valid = show;
            ctrl.advance  = show ? rsp_bus.ready : 1'b1;
         end
         default: begin
            ctrl = '0;
         end
      endcase
   end

   assign rsp_bus.digit_char = CHAR_ZERO + {{(CHAR_BITS-DIGIT_BITS){1'b0}}, top_digit};
   assign rsp_bus.last_digit = last_now;

   always_comb begin
      value_in     = value_ff;
      bit_cnt_in   = bit_cnt_ff;
      digit_cnt_in = digit_cnt_ff;
      started_in   = started_ff;
      overflow_in  = overflow_ff;
      if (req_take) begin
         value_in    = req_bus.value;
         bit_cnt_in  = CNT_W'(VALUE_BITS);
         overflow_in = 1'b0;
      end
      if (ctrl.dabble) begin
         value_in     = {value_ff[VALUE_BITS-2:0], 1'b0};
         bit_cnt_in   = bit_cnt_ff - CNT_W'(1);
         overflow_in  = overflow_ff | carry[MAX_DIGITS-1];
         digit_cnt_in = DCNT_W'(MAX_DIGITS);
         started_in   = 1'b0;
      end
      if (ctrl.advance) begin
         digit_cnt_in = digit_cnt_ff - DCNT_W'(1);
         started_in   = started_ff | show;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      value_ff     <= value_in;
      bit_cnt_ff   <= bit_cnt_in;
      digit_cnt_ff <= digit_cnt_in;
      started_ff   <= started_in;
      overflow_ff  <= overflow_in;
   end

`ifndef ASSERT_OFF
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_bus.ready && rsp_bus.valid))
      else $error("input taken while a digit is pending");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.digit_char >= CHAR_ZERO) &&
                        (rsp_bus.digit_char <= CHAR_ZERO + 6'd9))
      else $error("digit outside 0..9");

   a_load: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_CONVERT) && (bit_cnt_ff == CNT_W'(VALUE_BITS)))
      else $error("conversion did not start after input transaction");

   a_emit_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (digit_cnt_ff != '0))
      else $error("emit phase ran past the last digit");

   a_run_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && rsp_bus.last_digit) |=> (state_ff == ST_IDLE))
      else $error("not idle after last digit");
`endif

endmodule

// File: test/tb_top.sv
module tb_top
   import b2da_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned VALUE_BITS   = 32;
   localparam int unsigned MAX_DIGITS   = 10;
   localparam int unsigned RADIX        = 10;
   localparam int unsigned RANDOM_ITEMS = 250;
   localparam int unsigned STALL_LIMIT  = 2000;
   localparam int unsigned DRAIN_CYCLES = VALUE_BITS + MAX_DIGITS + 8;
   localparam int unsigned DIRECTED_ROWS = 20;

   typedef struct packed {
      logic [CHAR_BITS-1:0] digit_char;
      logic                 last_digit;
   } digit_item_type;

   logic clock;
   logic reset;

   b2da_req_if #(.VALUE_BITS(VALUE_BITS)) req_bus ();
   b2da_rsp_if                            rsp_bus ();

   binary_to_decimal_ascii #(
      .VALUE_BITS(VALUE_BITS),
      .MAX_DIGITS(MAX_DIGITS)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   // directed values; a nonempty text is the digit string typed in by hand
   logic [VALUE_BITS-1:0] directed_value [DIRECTED_ROWS] = '{
      32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd4294967295, 32'd2147483648,
      32'd1000000000, 32'd999999999, 32'd1234567890, 32'd4294967294, 32'h5555_5555,
      32'hAAAA_AAAA, 32'd65535, 32'd12345, 32'd7, 32'd90909, 32'h8000_0001, 32'd0
   };
   string directed_text [DIRECTED_ROWS] = '{
      "0", "1", "9", "10", "99", "100", "4294967295", "2147483648",
      "1000000000", "999999999", "1234567890", "", "",
      "", "", "", "7", "", "", "0"
   };

   digit_item_type        pending_digits[$];
   digit_item_type        got_digit;
   digit_item_type        want_digit;
   string                 typed_text;
   bit                    steady;
   int unsigned           error_count;
   int unsigned           values_sent;
   int unsigned           digits_seen;
   int unsigned           stall_cycles;
   bit [MAX_DIGITS:1]     lengths_seen;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // expected digit transactions for one value, most significant first
   function automatic void predict_digits(input logic [VALUE_BITS-1:0] number);
      logic [63:0]           rest;
      logic [DIGIT_BITS-1:0] digit_buf [20];
      int                    n;
      digit_item_type        item;
      rest = 64'(number);
      n = 0;
      do begin
         digit_buf[n] = DIGIT_BITS'(rest % RADIX);
         rest = rest / RADIX;
         n++;
      end while (rest != 0 && n < MAX_DIGITS);
      lengths_seen[n] = 1'b1;
      for (int k = n - 1; k >= 0; k--) begin
         item.digit_char = CHAR_ZERO + CHAR_BITS'(digit_buf[k]);
         item.last_digit = (k == 0);
         pending_digits.push_back(item);
      end
   endfunction

   function automatic void queue_typed_digits(input string text);
      digit_item_type item;
      lengths_seen[text.len()] = 1'b1;
      for (int k = 0; k < text.len(); k++) begin
         item.digit_char = CHAR_BITS'(text[k]);
         item.last_digit = (k == text.len() - 1);
         pending_digits.push_back(item);
      end
   endfunction

   function automatic void report_mismatch(input string what, input digit_item_type want,
                                            input digit_item_type got);
      error_count++;
      if (error_count <= 10) begin
         $display("%0t: %s: expected char %0d last %0b, got char %0d last %0b", $realtime,
                  what, want.digit_char, want.last_digit, got.digit_char, got.last_digit);
      end
   endfunction

   // sample both channels at the rising edge
   always @(posedge clock) begin
      stall_cycles++;
      if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         stall_cycles = 0;
         digits_seen++;
         got_digit.digit_char = rsp_bus.digit_char;
         got_digit.last_digit = rsp_bus.last_digit;
         if (pending_digits.size() == 0) begin
            report_mismatch("unexpected digit", '0, got_digit);
         end else begin
            want_digit = pending_digits.pop_front();
            if (got_digit.digit_char !== want_digit.digit_char ||
                got_digit.last_digit !== want_digit.last_digit) begin
               report_mismatch("digit mismatch", want_digit, got_digit);
            end
         end
      end
      if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
         stall_cycles = 0;
         values_sent++;
         if (typed_text.len() != 0) begin
            queue_typed_digits(typed_text);
         end else begin
            predict_digits(req_bus.value);
         end
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Timeout: no transaction for %0d cycles", stall_cycles);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // receiver backpressure
   always @(negedge clock) begin
      if (!reset) begin
         rsp_bus.ready <= steady || ($urandom_range(99) >= 7);
      end
   end

   task automatic send_value(input logic [VALUE_BITS-1:0] number, input string text);
      while (!steady && $urandom_range(99) < 7) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      typed_text = text;
      req_bus.valid <= 1'b1;
      req_bus.value <= number;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (pending_digits.size() != 0) @(negedge clock);
   endtask

   initial begin
      logic [VALUE_BITS-1:0] number;
      logic [VALUE_BITS-1:0] power;
      error_count   = 0;
      values_sent   = 0;
      digits_seen   = 0;
      stall_cycles  = 0;
      lengths_seen  = '0;
      steady        = 1'b0;
      typed_text    = "";
      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.value = '0;
      rsp_bus.ready = 1'b0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         send_value(directed_value[i], directed_text[i]);
      end
      wait_drained();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         steady = (i >= 80 && i < 140);
         power = 1;
         repeat ($urandom_range(0, 9)) power = power * RADIX;
         case ($urandom_range(0, 9))
            0, 1, 2, 3: number = $urandom;
            4, 5:       number = $urandom_range(0, 99);
            6:          number = power + $urandom_range(0, 2) - 1;
            7:          number = $urandom >> $urandom_range(0, 31);
            8:          number = power - 1;
            default:    number = $urandom_range(0, 99999);
         endcase
         if (i == 170) begin
            wait_drained();
         end
         send_value(number, "");
      end
      steady = 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Converted %0d values into %0d digit transactions", values_sent, digits_seen);
      $display("Digit string lengths seen (bit n = n digits): %b", lengths_seen);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("Mismatches: %0d", error_count);
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
